// File: hw/rtl/bmr_pkg.sv
// shared types and constants for the band mean rounding block
package bmr_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int EXT_W      = SAMPLE_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int COUNT_W    = 7;
    localparam int FMT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 1'b1;

    localparam logic [FMT_W-1:0] FMT_S8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_U8  = 3'd1;
    localparam logic [FMT_W-1:0] FMT_S16 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_U16 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_S32 = 3'd4;
    localparam logic [FMT_W-1:0] FMT_U32 = 3'd5;

    typedef struct packed {
        logic accept;
        logic div_load;
        logic div_prep;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last_band;
    } status_t;

endpackage

// File: hw/rtl/bmr_datapath.sv
// accumulator, config registers, bit-serial divider and output register
module bmr_datapath #(
    parameter int MAX_BANDS = 64,
    parameter int SUM_W     = 39,
    parameter int B_W       = 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bmr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [bmr_pkg::SAMPLE_W-1:0]   sample,
    input  bmr_pkg::cmd_t                  cmd,
    output bmr_pkg::status_t               status,
    output logic [bmr_pkg::SAMPLE_W-1:0]   mean
);

    logic [bmr_pkg::COUNT_W-1:0] band_count_reg;
    logic [bmr_pkg::FMT_W-1:0]   format_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [SUM_W-1:0]     sum_next;
    logic [B_W-1:0]              pos_reg;
    logic [SUM_W-1:0]            dq_reg;
    logic [SUM_W-1:0]            dq_next;
    logic [B_W-1:0]              rem_reg;
    logic [B_W-1:0]              rem_next;
    logic                        neg_reg;
    logic [bmr_pkg::SAMPLE_W-1:0] mean_reg;
    logic [bmr_pkg::SAMPLE_W-1:0] mean_next;

    logic [B_W-1:0]               bands;
    logic [B_W-1:0]               half;
    logic signed [bmr_pkg::EXT_W-1:0] ext;
    logic [bmr_pkg::SAMPLE_W-1:0] mask;
    logic [B_W:0]                 trial;
    logic [SUM_W-1:0]             signed_q;

    // effective band count
    always_comb begin
        if (band_count_reg == '0) begin
            bands = B_W'(1);
        end else if (int'(band_count_reg) > MAX_BANDS) begin
            bands = B_W'(MAX_BANDS);
        end else begin
            bands = B_W'(band_count_reg);
        end
        half = bands >> 1;
    end

    always_comb begin
        case (format_reg)
            bmr_pkg::FMT_S8: begin
                ext  = bmr_pkg::EXT_W'($signed(sample[7:0]));
                mask = 32'h0000_00ff;
            end
            bmr_pkg::FMT_U8: begin
                ext  = $signed({25'd0, sample[7:0]});
                mask = 32'h0000_00ff;
            end
            bmr_pkg::FMT_S16: begin
                ext  = bmr_pkg::EXT_W'($signed(sample[15:0]));
                mask = 32'h0000_ffff;
            end
            bmr_pkg::FMT_U16: begin
                ext  = $signed({17'd0, sample[15:0]});
                mask = 32'h0000_ffff;
            end
            bmr_pkg::FMT_S32: begin
                ext  = bmr_pkg::EXT_W'($signed(sample));
                mask = 32'hffff_ffff;
            end
            default: begin
                ext  = $signed({1'b0, sample});
                mask = 32'hffff_ffff;
            end
        endcase
    end

    assign sum_next = sum_reg + SUM_W'(ext);
    assign status.last_band = (pos_reg == bands - B_W'(1));

    // one quotient bit per step
    always_comb begin
        trial = {rem_reg, dq_reg[SUM_W-1]};
        if (trial >= {1'b0, bands}) begin
            rem_next = B_W'(trial - {1'b0, bands});
            dq_next  = {dq_reg[SUM_W-2:0], 1'b1};
        end else begin
            rem_next = trial[B_W-1:0];
            dq_next  = {dq_reg[SUM_W-2:0], 1'b0};
        end
    end

    assign signed_q  = neg_reg ? (~dq_reg + SUM_W'(1)) : dq_reg;
    assign mean_next = signed_q[bmr_pkg::SAMPLE_W-1:0] & mask;
    assign mean      = mean_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_count_reg <= bmr_pkg::COUNT_W'(1);
            format_reg     <= bmr_pkg::FMT_U8;
            sum_reg        <= '0;
            pos_reg        <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bmr_pkg::CFG_BAND_COUNT:    band_count_reg <= cfg_wdata;
                bmr_pkg::CFG_SAMPLE_FORMAT: format_reg     <= cfg_wdata[bmr_pkg::FMT_W-1:0];
                default: ;
            endcase
            sum_reg <= '0;
            pos_reg <= '0;
        end else if (cmd.div_load) begin
            sum_reg <= '0;
            pos_reg <= '0;
        end else if (cmd.accept) begin
            sum_reg <= sum_next;
            pos_reg <= pos_reg + B_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            dq_reg  <= sum_next;
            neg_reg <= sum_next[SUM_W-1];
        end else if (cmd.div_prep) begin
            // magnitude plus half, one add with carry-in for negatives
            dq_reg  <= (neg_reg ? ~dq_reg : dq_reg) + SUM_W'(half) + SUM_W'(neg_reg);
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
        if (cmd.out_load) begin
            mean_reg <= mean_next;
        end
    end

endmodule

// File: hw/rtl/bmr_ctrl.sv
// controller state machine for accumulate, divide and output
module bmr_ctrl #(
    parameter int SUM_W = 39
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  bmr_pkg::status_t status,
    output bmr_pkg::cmd_t    cmd
);

    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [1:0] {
        ST_ACC,
        ST_PREP,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;

    assign s_tready = (state_reg == ST_ACC);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd.accept   = s_tvalid && s_tready;
        cmd.div_load = cmd.accept && status.last_band;
        cmd.div_prep = (state_reg == ST_PREP);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.out_load = (state_reg == ST_HOLD) && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_ACC: begin
                    if (cmd.div_load) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(SUM_W - 1)) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (cmd.out_load) begin
                        state_reg <= ST_ACC;
                    end
                end
                default: state_reg <= ST_ACC;
            endcase
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: hw/rtl/band_mean_rounding.sv
// Multiband pixel mean: takes one band sample per cycle while accepting, sums the samples of a pixel
// (band_count, with 0 read as 1 and clamped to MAX_BANDS) in a signed accumulator of 33 + log2(MAX_BANDS)
// bits, then divides by the band count with rounding half away from zero and returns the mean in the
// sample's own format. A pixel goes through its accepted samples, a step that forms the rounded
// magnitude, SUM_W steps of the one-bit-per-cycle restoring divider, and a load of the output
// register; the input is held off from the last sample until the output register is loaded. A finished
// mean waits in the output register, so the next pixel's samples are taken while it is pending.
// Any configuration write drops a partly summed pixel.
module band_mean_rounding #(
    parameter int MAX_BANDS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bmr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bmr_pkg::SAMPLE_W-1:0]   s_tdata,   // [31:0] sample_bits
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bmr_pkg::SAMPLE_W-1:0]   m_tdata    // [31:0] mean_bits
);

    localparam int SUM_W = bmr_pkg::EXT_W + $clog2(MAX_BANDS);
    localparam int B_W   = $clog2(MAX_BANDS + 1);

    bmr_pkg::cmd_t    cmd;
    bmr_pkg::status_t status;

    bmr_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bmr_datapath #(
        .MAX_BANDS (MAX_BANDS),
        .SUM_W     (SUM_W),
        .B_W       (B_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .sample    (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .mean      (m_tdata)
    );

endmodule

// File: hw/rtl/bmr_checker.sv
// port-level checks for the band mean rounding block
module bmr_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bmr_pkg::SAMPLE_W-1:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

    // reset leaves no result pending
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
    else $error("result valid after reset");

    // input closes only after a request was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
    else $error("input closed without a request");

    // a new result is loaded only while the input is held off
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result loaded while accumulating");

endmodule

bind band_mean_rounding bmr_checker u_bmr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/tb.sv
// self-checking testbench for band_mean_rounding: directed table, then random pixel streams
module tb;

    localparam int MAX_BANDS    = 64;
    localparam int ITEMS        = 450;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [bmr_pkg::FMT_W-1:0] FMT_SPARE = 3'd7;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t                      kind;
        logic [bmr_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [bmr_pkg::CFG_DATA_W-1:0] reg_val;
        logic [bmr_pkg::SAMPLE_W-1:0]   sample;
        bit                             typed;
        logic [bmr_pkg::SAMPLE_W-1:0]   mean;
    } stim_row_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [bmr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bmr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [bmr_pkg::SAMPLE_W-1:0]   s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [bmr_pkg::SAMPLE_W-1:0]   m_tdata;

    // predictor state and its copy of the registers
    logic [bmr_pkg::COUNT_W-1:0]    cur_bands;
    logic [bmr_pkg::FMT_W-1:0]      cur_format;
    longint                         band_acc;
    int                             band_pos;

    logic [bmr_pkg::SAMPLE_W-1:0]   pending_means[$];
    stim_row_t                      stim_rows[$];
    logic [bmr_pkg::SAMPLE_W-1:0]   want_mean;

    int errors      = 0;
    int sent        = 0;
    bit sender_calm = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    bit quiet       = 1'b0;
    bit ready_calm  = 1'b0;
    int stall_left  = 0;
    int calm_left   = 0;

    band_mean_rounding #(.MAX_BANDS(MAX_BANDS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint eff_bands();
        if (cur_bands == 0) return 1;
        if (cur_bands > MAX_BANDS) return MAX_BANDS;
        return longint'(cur_bands);
    endfunction

    function automatic logic [bmr_pkg::SAMPLE_W-1:0] fmt_mask();
        case (cur_format)
            bmr_pkg::FMT_S8, bmr_pkg::FMT_U8:   return 32'h0000_00FF;
            bmr_pkg::FMT_S16, bmr_pkg::FMT_U16: return 32'h0000_FFFF;
            default:                            return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic bit predict_mean(input logic [bmr_pkg::SAMPLE_W-1:0] raw,
                                        output logic [bmr_pkg::SAMPLE_W-1:0] mean);
        longint ext;
        longint q;
        longint b;
        longint half;
        b    = eff_bands();
        half = b / 2;
        case (cur_format)
            bmr_pkg::FMT_S8:  ext = longint'($signed(raw[7:0]));
            bmr_pkg::FMT_U8:  ext = longint'(raw[7:0]);
            bmr_pkg::FMT_S16: ext = longint'($signed(raw[15:0]));
            bmr_pkg::FMT_U16: ext = longint'(raw[15:0]);
            bmr_pkg::FMT_S32: ext = longint'($signed(raw));
            default:          ext = longint'(raw);
        endcase
        band_acc = band_acc + ext;
        band_pos = band_pos + 1;
        mean = '0;
        if (band_pos < b) return 1'b0;
        if (band_acc > 0)
            q = (band_acc + half) / b;
        else if (band_acc < 0)
            q = -((-band_acc + half) / b);
        else
            q = 0;
        mean     = q[31:0] & fmt_mask();
        band_acc = 0;
        band_pos = 0;
        return 1'b1;
    endfunction

    // all ones, zero, the extremes of the current format with random upper bits, or a random sample
    function automatic logic [bmr_pkg::SAMPLE_W-1:0] pick_sample();
        logic [bmr_pkg::SAMPLE_W-1:0] m;
        logic [bmr_pkg::SAMPLE_W-1:0] r;
        m = fmt_mask();
        r = $urandom;
        case ($urandom_range(0, 5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0000_0000;
            2:       return (r & ~m) | (m ^ (m >> 1));
            3:       return (r & ~m) | (m >> 1);
            default: return r;
        endcase
    endfunction

    function automatic void add_cfg(input logic [bmr_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [bmr_pkg::CFG_DATA_W-1:0] val);
        stim_row_t row;
        row = '{ROW_CFG, idx, val, '0, 1'b0, '0};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_smp(input logic [bmr_pkg::SAMPLE_W-1:0] smp);
        stim_row_t row;
        row = '{ROW_SAMPLE, '0, '0, smp, 1'b0, '0};
        stim_rows.push_back(row);
    endfunction

    function automatic void add_chk(input logic [bmr_pkg::SAMPLE_W-1:0] smp,
                                    input logic [bmr_pkg::SAMPLE_W-1:0] mean);
        stim_row_t row;
        row = '{ROW_SAMPLE, '0, '0, smp, 1'b1, mean};
        stim_rows.push_back(row);
    endfunction

    task automatic push_sample(input logic [bmr_pkg::SAMPLE_W-1:0] smp, input bit typed,
                               input logic [bmr_pkg::SAMPLE_W-1:0] typed_mean);
        logic [bmr_pkg::SAMPLE_W-1:0] mean;
        if (!quiet && !sender_calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (s_tready !== 1'b1);
        sent = sent + 1;
        if (predict_mean(smp, mean))
            pending_means.push_back(typed ? typed_mean : mean);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [bmr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bmr_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx == bmr_pkg::CFG_BAND_COUNT)
            cur_bands = val;
        else
            cur_format = val[bmr_pkg::FMT_W-1:0];
        band_acc = 0;
        band_pos = 0;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // result checking and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_means.size() == 0) begin
                $display("%0t: request with no mean pending, expected none, actual %h",
                         $time, m_tdata);
                errors = errors + 1;
            end else begin
                want_mean = pending_means.pop_front();
                if (m_tdata !== want_mean) begin
                    $display("%0t: mean mismatch, expected %h, actual %h",
                             $time, want_mean, m_tdata);
                    errors = errors + 1;
                end
            end
        end
        if (calm_left == 0) begin
            calm_left  = 64;
            ready_calm = ($urandom_range(0, 2) == 0);
        end else begin
            calm_left = calm_left - 1;
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (!quiet && !ready_calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        stim_row_t                    row;
        int                           phase;
        int                           npix;
        int                           nb;
        int                           sel;
        logic [bmr_pkg::COUNT_W-1:0]  cnt_val;
        logic [bmr_pkg::FMT_W-1:0]    fmt_val;
        logic [bmr_pkg::SAMPLE_W-1:0] fixed;

        // after reset: one band, u8
        add_chk(32'h0000_00FF, 32'h0000_00FF);
        add_chk(32'hFFFF_FF00, 32'h0000_0000);
        add_cfg(bmr_pkg::CFG_SAMPLE_FORMAT, 7'(bmr_pkg::FMT_S8));
        add_chk(32'h0000_0080, 32'h0000_0080);
        add_chk(32'hFFFF_FF7F, 32'h0000_007F);
        add_cfg(bmr_pkg::CFG_SAMPLE_FORMAT, 7'(bmr_pkg::FMT_U32));
        add_chk(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_chk(32'h0000_0000, 32'h0000_0000);
        add_cfg(bmr_pkg::CFG_SAMPLE_FORMAT, 7'(bmr_pkg::FMT_S32));
        add_chk(32'h8000_0000, 32'h8000_0000);
        add_chk(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_cfg(bmr_pkg::CFG_SAMPLE_FORMAT, 7'(bmr_pkg::FMT_U16));
        add_chk(32'h0001_FFFF, 32'h0000_FFFF);
        // unused format code acts as u32
        add_cfg(bmr_pkg::CFG_SAMPLE_FORMAT, {4'b1111, FMT_SPARE});
        add_chk(32'hDEAD_BEEF, 32'hDEAD_BEEF);
        // zero band count acts as one band
        add_cfg(bmr_pkg::CFG_BAND_COUNT, 7'd0);
        add_cfg(bmr_pkg::CFG_SAMPLE_FORMAT, 7'(bmr_pkg::FMT_S16));
        add_chk(32'h0000_8000, 32'h0000_8000);
        // two bands: -1.5 rounds to -2, 1.5 to 2, zero sum
        add_cfg(bmr_pkg::CFG_BAND_COUNT, 7'd2);
        add_smp(32'h0000_FFFF);
        add_chk(32'h0000_FFFE, 32'h0000_FFFE);
        add_smp(32'h0000_0001);
        add_chk(32'h0000_0002, 32'h0000_0002);
        add_smp(32'h0000_0001);
        add_chk(32'h0000_FFFF, 32'h0000_0000);
        // partial pixel dropped by a register write
        add_cfg(bmr_pkg::CFG_BAND_COUNT, 7'd3);
        add_cfg(bmr_pkg::CFG_SAMPLE_FORMAT, 7'(bmr_pkg::FMT_U8));
        add_smp(32'h0000_0005);
        add_cfg(bmr_pkg::CFG_SAMPLE_FORMAT, 7'(bmr_pkg::FMT_U8));
        add_smp(32'h0000_0001);
        add_smp(32'h0000_0002);
        add_chk(32'h0000_0002, 32'h0000_0002);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        cur_bands  = 7'd1;
        cur_format = bmr_pkg::FMT_U8;
        band_acc   = 0;
        band_pos   = 0;

        for (int i = 0; i < stim_rows.size(); i++) begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                push_sample(row.sample, row.typed, row.mean);
            end
        end

        for (phase = 0; sent < ITEMS; phase++) begin
            if (sent >= ITEMS - 60) quiet <= 1'b1;
            settle();
            fixed = '0;
            npix  = $urandom_range(2, 8);
            sender_calm = ($urandom_range(0, 3) == 0);
            case (phase)
                0: begin
                    cnt_val = 7'd64;
                    fmt_val = bmr_pkg::FMT_S32;
                    fixed   = 32'h8000_0000;
                    npix    = 1;
                end
                1: begin
                    cnt_val = 7'd127;
                    fmt_val = bmr_pkg::FMT_U32;
                    fixed   = 32'hFFFF_FFFF;
                    npix    = 1;
                end
                2: begin
                    cnt_val = 7'd2;
                    fmt_val = bmr_pkg::FMT_U16;
                    npix    = 30;
                    sender_calm = 1'b1;
                end
                default: begin
                    sel     = $urandom_range(0, 15);
                    fmt_val = 3'($urandom_range(0, 7));
                    if (sel < 3)
                        cnt_val = 7'($urandom_range(0, 1));
                    else if (sel < 11)
                        cnt_val = 7'($urandom_range(2, 8));
                    else if (sel < 14)
                        cnt_val = 7'($urandom_range(9, 20));
                    else if (sel == 14)
                        cnt_val = 7'd64;
                    else
                        cnt_val = 7'($urandom_range(65, 127));
                    if (sel >= 11) npix = 1;
                end
            endcase
            write_reg(bmr_pkg::CFG_BAND_COUNT, cnt_val);
            write_reg(bmr_pkg::CFG_SAMPLE_FORMAT, {4'($urandom_range(0, 15)), fmt_val});
            if (phase == 2) hold_req <= 1'b1;
            nb = int'(eff_bands());
            for (int p = 0; p < npix; p++)
                for (int k = 0; k < nb; k++)
                    push_sample(phase < 2 ? fixed : pick_sample(), 1'b0, '0);
            if (!quiet && nb > 1 && $urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, nb - 1)) push_sample(pick_sample(), 1'b0, '0);
        end

        settle();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
